// File: rtl/core/swts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swts_pkg
// Shared types and constants for the sliding-window trade statistics block.
// ----------------------------------------------------------------------------
package swts_pkg;

    localparam int RING_DEPTH_DEF = 1024;

    localparam int PRICE_W = 31;
    localparam int QTY_W   = 32;
    localparam int TNS_W   = 64;
    localparam int NOW_W   = 35;
    localparam int WIN_W   = 17;
    localparam int CNT_O_W = 11;
    localparam int NSX_W   = 65;   // seconds scaled to ns, no overflow

    localparam logic [29:0]      NS_PER_SEC   = 30'd1000000000;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 17'd600;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_EVICT  = 1'b1;

    typedef enum logic [1:0] {
        CH_HOLD,
        CH_INSERT,
        CH_REMOVE
    } chain_op_t;

    typedef struct packed {
        chain_op_t          op;
        logic [PRICE_W-1:0] price;
    } chain_cmd_t;

    // Prices picked out of the sorted chain for the result
    typedef struct packed {
        logic [PRICE_W-1:0] hi;
        logic [PRICE_W-1:0] mid;
        logic [PRICE_W-1:0] midlo;
        logic [PRICE_W-1:0] lo;
    } chain_view_t;

endpackage

// File: rtl/core/swts_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swts_cell
// One slot of the sorted price chain: holds a price, shifts on insert/remove.
// ----------------------------------------------------------------------------
module swts_cell
    import swts_pkg::*;
#(
    parameter int IDX_W = 10,
    parameter int IDX   = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  chain_cmd_t         cmd,
    input  logic [PRICE_W-1:0] left_price,
    input  logic               left_valid,
    input  logic [PRICE_W-1:0] right_price,
    input  logic               right_valid,
    input  logic [IDX_W-1:0]   tgt_hi,
    input  logic [IDX_W-1:0]   tgt_mid,
    input  logic [IDX_W-1:0]   tgt_midlo,
    output logic [PRICE_W-1:0] price,
    output logic               valid,
    output logic [2:0]         sel
);

    logic [PRICE_W-1:0] price_reg, price_next;
    logic               valid_reg, valid_next;
    logic               gt_self, gt_left, ge_self;

    assign gt_self = valid_reg && (price_reg > cmd.price);
    assign gt_left = left_valid && (left_price > cmd.price);
    assign ge_self = valid_reg && (price_reg >= cmd.price);

    always_comb
    begin
        price_next = price_reg;
        valid_next = valid_reg;
        unique case (cmd.op)
            CH_INSERT:
            begin
                // insert after equal prices; larger ones move right
                if (gt_left)
                    price_next = left_price;
                else if (gt_self || !valid_reg)
                    price_next = cmd.price;
                valid_next = left_valid;
            end
            CH_REMOVE:
            begin
                if (ge_self)
                    price_next = right_price;
                valid_next = right_valid;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
    end

    assign price = price_reg;
    assign valid = valid_reg;
    assign sel   = {tgt_hi == IDX_W'(IDX), tgt_mid == IDX_W'(IDX), tgt_midlo == IDX_W'(IDX)};

endmodule

// File: rtl/core/swts_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swts_chain
// Row of sorted price cells plus a two-level readout tree, first level registered.
// ----------------------------------------------------------------------------
module swts_chain
    import swts_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int CNT_W      = $clog2(RING_DEPTH + 1),
    parameter int IDX_W      = $clog2(RING_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  chain_cmd_t       cmd,
    input  logic [CNT_W-1:0] count,
    output chain_view_t      view
);

    localparam int GRP  = 32;
    localparam int NGRP = (RING_DEPTH + GRP - 1) / GRP;

    logic [PRICE_W-1:0] price_arr [RING_DEPTH];
    logic               valid_arr [RING_DEPTH];
    logic [2:0]         sel_arr   [RING_DEPTH];

    logic [CNT_W-1:0] hi_full, mid_full, midlo_full;
    logic [IDX_W-1:0] tgt_hi, tgt_mid, tgt_midlo;

    assign hi_full    = count - CNT_W'(1);
    assign mid_full   = count >> 1;
    assign midlo_full = mid_full - CNT_W'(1);
    assign tgt_hi     = hi_full[IDX_W-1:0];
    assign tgt_mid    = mid_full[IDX_W-1:0];
    assign tgt_midlo  = midlo_full[IDX_W-1:0];

    for (genvar i = 0; i < RING_DEPTH; i++)
    begin : g_cell
        logic [PRICE_W-1:0] lp, rp;
        logic               lv, rv;
        if (i == 0)
        begin : g_first
            assign lp = '0;
            assign lv = 1'b1;
        end
        else
        begin : g_mid_l
            assign lp = price_arr[i-1];
            assign lv = valid_arr[i-1];
        end
        if (i == RING_DEPTH - 1)
        begin : g_last
            assign rp = '0;
            assign rv = 1'b0;
        end
        else
        begin : g_mid_r
            assign rp = price_arr[i+1];
            assign rv = valid_arr[i+1];
        end

        swts_cell #(
            .IDX_W (IDX_W),
            .IDX   (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_price  (lp),
            .left_valid  (lv),
            .right_price (rp),
            .right_valid (rv),
            .tgt_hi      (tgt_hi),
            .tgt_mid     (tgt_mid),
            .tgt_midlo   (tgt_midlo),
            .price       (price_arr[i]),
            .valid       (valid_arr[i]),
            .sel         (sel_arr[i])
        );
    end

    // first level: one-hot select within each group of cells, registered
    logic [PRICE_W-1:0] grp_hi_next [NGRP], grp_mid_next [NGRP], grp_midlo_next [NGRP];
    logic [PRICE_W-1:0] grp_hi_reg  [NGRP], grp_mid_reg  [NGRP], grp_midlo_reg  [NGRP];

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_hi_next[g]    = '0;
            grp_mid_next[g]   = '0;
            grp_midlo_next[g] = '0;
            for (int j = 0; j < GRP; j++)
            begin
                if (g * GRP + j < RING_DEPTH)
                begin
                    grp_hi_next[g]    = grp_hi_next[g]
                                      | (price_arr[g*GRP+j] & {PRICE_W{sel_arr[g*GRP+j][2]}});
                    grp_mid_next[g]   = grp_mid_next[g]
                                      | (price_arr[g*GRP+j] & {PRICE_W{sel_arr[g*GRP+j][1]}});
                    grp_midlo_next[g] = grp_midlo_next[g]
                                      | (price_arr[g*GRP+j] & {PRICE_W{sel_arr[g*GRP+j][0]}});
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_hi_reg[g]    <= grp_hi_next[g];
            grp_mid_reg[g]   <= grp_mid_next[g];
            grp_midlo_reg[g] <= grp_midlo_next[g];
        end
    end

    // second level: merge the groups
    always_comb
    begin
        view.hi    = '0;
        view.mid   = '0;
        view.midlo = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            view.hi    = view.hi    | grp_hi_reg[g];
            view.mid   = view.mid   | grp_mid_reg[g];
            view.midlo = view.midlo | grp_midlo_reg[g];
        end
        view.lo = price_arr[0];
    end

endmodule

// File: rtl/core/sliding_window_trade_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_trade_stats
// Trailing-window trade ring with running sums and a sorted price chain for
// max, min and median.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  in       | in_valid / in_stall    | operation, trade_time_ns, trade_price,
//           |                        | trade_quantity, now_seconds
//  out      | out_valid / out_stall  | live_trades, quantity_sum, amount_sum,
//           |                        | highest_price, lowest_price, median_price
//  cfg      | cfg_we                 | window_length
//
//  Record: write ring and chain, add to the sums; when the ring is full the
//  oldest trade is read and dropped first.
//  Evict: read and drop oldest trades until one stays in the window; no
//  stopping check when the ring runs empty. The single-port ring read and the
//  one-shift-per-cycle chain set the steps; a new item is taken only in idle.
//  Reset clears count, pointers, sums, and cell valid bits; no clearing pass.
//  A stalled result sits in the output register; the next item is still taken.
// ----------------------------------------------------------------------------
module sliding_window_trade_stats
    import swts_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [WIN_W-1:0]    window_length,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  logic [TNS_W-1:0]    trade_time_ns,
    input  logic [PRICE_W-1:0]  trade_price,
    input  logic [QTY_W-1:0]    trade_quantity,
    input  logic [NOW_W-1:0]    now_seconds,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CNT_O_W-1:0]  live_trades,
    output logic [63:0]         quantity_sum,
    output logic [63:0]         amount_sum,
    output logic signed [31:0]  highest_price,
    output logic signed [31:0]  lowest_price,
    output logic [PRICE_W-1:0]  median_price
);

    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int PROD_W = PRICE_W + QTY_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMUL,   // scale now / cutoff to nanoseconds
        S_RD,     // read oldest slot
        S_EXAM,   // decide drop, start remove in chain
        S_SUB,    // take dropped trade out of the sums
        S_INS,    // write head slot, insert into chain
        S_ADD,    // add new trade to the sums
        S_FIN1,   // readout tree first level
        S_FIN2    // load result register
    } state_t;

    // ring storage, times kept in ns so eviction compares need no divide
    logic [TNS_W-1:0]   time_mem  [RING_DEPTH];
    logic [PRICE_W-1:0] price_mem [RING_DEPTH];
    logic [QTY_W-1:0]   qty_mem   [RING_DEPTH];

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [63:0]        qsum_reg, qsum_next;
    logic [63:0]        asum_reg, asum_next;
    logic [WIN_W-1:0]   win_reg, win_next;
    logic               out_valid_reg, out_valid_next;

    logic               op_reg;
    logic [TNS_W-1:0]   tns_reg;
    logic [PRICE_W-1:0] pin_reg;
    logic [QTY_W-1:0]   qin_reg;
    logic [NOW_W-1:0]   now_reg;
    logic [NOW_W-1:0]   cut_reg;
    logic               all_reg;
    logic [NSX_W-1:0]   now_ns_reg, cut_ns_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TNS_W-1:0]   rd_time_reg;
    logic [PRICE_W-1:0] rd_price_reg;
    logic [QTY_W-1:0]   rd_qty_reg;

    logic [CNT_O_W-1:0] o_cnt_reg;
    logic [63:0]        o_qsum_reg, o_asum_reg;
    logic [31:0]        o_hi_reg, o_lo_reg;
    logic [PRICE_W-1:0] o_med_reg;

    chain_cmd_t  ch_cmd;
    chain_view_t ch_view;

    logic        accept, load_out, drop;
    logic [NSX_W-1:0] rd_time_x;
    logic [31:0] cnt_ext;
    logic [31:0] mid_sum;
    logic        empty;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign load_out = (state_reg == S_FIN2) && (!out_valid_reg || !out_stall);
    assign in_stall = (state_reg != S_IDLE);

    // trade stays if now >= window and cutoff <= t < now (in ns); window/now bounds on seconds
    assign rd_time_x = NSX_W'(rd_time_reg);
    assign drop = (op_reg == OP_RECORD) || all_reg
               || !((rd_time_x >= cut_ns_reg) && (rd_time_x < now_ns_reg));

    always_comb
    begin
        ch_cmd.op    = CH_HOLD;
        ch_cmd.price = pin_reg;
        if (state_reg == S_EXAM && drop)
        begin
            ch_cmd.op    = CH_REMOVE;
            ch_cmd.price = rd_price_reg;
        end
        else if (state_reg == S_INS)
            ch_cmd.op = CH_INSERT;
    end

    swts_chain #(
        .RING_DEPTH (RING_DEPTH),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ch_cmd),
        .count (count_reg),
        .view  (ch_view)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        qsum_next      = qsum_reg;
        asum_next      = asum_reg;
        win_next       = cfg_we ? window_length : win_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_EVICT)
                        state_next = S_EMUL;
                    else if (count_reg == CNT_W'(RING_DEPTH))
                        state_next = S_RD;
                    else
                        state_next = S_INS;
                end
            end
            S_EMUL:
            begin
                state_next = (count_reg == '0) ? S_FIN1 : S_RD;
            end
            S_RD:
            begin
                state_next = S_EXAM;
            end
            S_EXAM:
            begin
                state_next = drop ? S_SUB : S_FIN1;
            end
            S_SUB:
            begin
                qsum_next  = qsum_reg - 64'(rd_qty_reg);
                asum_next  = asum_reg - 64'(prod_reg);
                count_next = count_reg - CNT_W'(1);
                tail_next  = (tail_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : tail_reg + IDX_W'(1);
                if (op_reg == OP_RECORD)
                    state_next = S_INS;
                else if (count_reg == CNT_W'(1))
                    state_next = S_FIN1;
                else
                    state_next = S_RD;
            end
            S_INS:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                qsum_next  = qsum_reg + 64'(qin_reg);
                asum_next  = asum_reg + 64'(prod_reg);
                count_next = count_reg + CNT_W'(1);
                head_next  = (head_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
                state_next = S_FIN1;
            end
            S_FIN1:
            begin
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            qsum_reg      <= '0;
            asum_reg      <= '0;
            win_reg       <= WINDOW_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            qsum_reg      <= qsum_next;
            asum_reg      <= asum_next;
            win_reg       <= win_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result formatting
    assign empty   = (count_reg == '0);
    assign cnt_ext = 32'(count_reg);
    assign mid_sum = 32'(ch_view.mid) + 32'(ch_view.midlo);

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            tns_reg <= trade_time_ns;
            pin_reg <= trade_price;
            qin_reg <= trade_quantity;
            now_reg <= now_seconds;
            cut_reg <= now_seconds - NOW_W'(win_reg);
            all_reg <= (now_seconds < NOW_W'(win_reg));
        end
        if (state_reg == S_EMUL)
        begin
            now_ns_reg <= NSX_W'(now_reg) * NSX_W'(NS_PER_SEC);
            cut_ns_reg <= NSX_W'(cut_reg) * NSX_W'(NS_PER_SEC);
        end
        if (state_reg == S_EXAM)
            prod_reg <= PROD_W'(rd_price_reg) * PROD_W'(rd_qty_reg);
        if (state_reg == S_INS)
            prod_reg <= PROD_W'(pin_reg) * PROD_W'(qin_reg);
        if (load_out)
        begin
            o_cnt_reg  <= cnt_ext[CNT_O_W-1:0];
            o_qsum_reg <= qsum_reg;
            o_asum_reg <= asum_reg;
            o_hi_reg   <= empty ? 32'h8000_0000 : {1'b0, ch_view.hi};
            o_lo_reg   <= empty ? 32'h7FFF_FFFF : {1'b0, ch_view.lo};
            if (empty)
                o_med_reg <= '0;
            else if (count_reg[0])
                o_med_reg <= ch_view.mid;
            else
                o_med_reg <= mid_sum[PRICE_W:1];
        end
    end

    // ring memory: one write (head), one registered read (tail)
    always_ff @(posedge clk)
    begin
        if (state_reg == S_INS)
        begin
            time_mem[head_reg]  <= tns_reg;
            price_mem[head_reg] <= pin_reg;
            qty_mem[head_reg]   <= qin_reg;
        end
        if (state_reg == S_RD)
        begin
            rd_time_reg  <= time_mem[tail_reg];
            rd_price_reg <= price_mem[tail_reg];
            rd_qty_reg   <= qty_mem[tail_reg];
        end
    end

    assign out_valid     = out_valid_reg;
    assign live_trades   = o_cnt_reg;
    assign quantity_sum  = o_qsum_reg;
    assign amount_sum    = o_asum_reg;
    assign highest_price = o_hi_reg;
    assign lowest_price  = o_lo_reg;
    assign median_price  = o_med_reg;

endmodule

// File: rtl/core/swts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swts_checker
// Port-level checks on the result channel of the trade statistics block.
// ----------------------------------------------------------------------------
module swts_checker
    import swts_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                cfg_we,
    input logic [WIN_W-1:0]    window_length,
    input logic                in_valid,
    input logic                in_stall,
    input logic                operation,
    input logic [TNS_W-1:0]    trade_time_ns,
    input logic [PRICE_W-1:0]  trade_price,
    input logic [QTY_W-1:0]    trade_quantity,
    input logic [NOW_W-1:0]    now_seconds,
    input logic                out_valid,
    input logic                out_stall,
    input logic [CNT_O_W-1:0]  live_trades,
    input logic [63:0]         quantity_sum,
    input logic [63:0]         amount_sum,
    input logic signed [31:0]  highest_price,
    input logic signed [31:0]  lowest_price,
    input logic [PRICE_W-1:0]  median_price
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(amount_sum) && $stable(median_price))
        else $error("stalled result changed");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && live_trades == '0 |-> highest_price == 32'sh8000_0000
            && lowest_price == 32'sh7FFF_FFFF && median_price == '0)
        else $error("empty result has wrong extremes");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && live_trades == CNT_O_W'(1) |-> highest_price == lowest_price
            && median_price == lowest_price[PRICE_W-1:0])
        else $error("single trade result inconsistent");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && live_trades != '0 |-> lowest_price <= highest_price
            && $signed({1'b0, median_price}) >= lowest_price
            && $signed({1'b0, median_price}) <= highest_price)
        else $error("median outside price range");

endmodule

bind sliding_window_trade_stats swts_checker u_swts_checker (.*);
